/* rtl/dms_pkg.sv */
// Shared constants, twiddle table and command/status types for the DFT magnitude block.
`timescale 1ns / 1ps
package dms_pkg;
	localparam int FrameSize = 128;
	localparam int IdxW = 7;
	localparam int BinW = 6;
	localparam int SampleW = 16;
	localparam int MagW = 24;
	localparam int AccW = 40;
	localparam int PowW = 80;
	localparam int RootW = 41;
	localparam int DivShift = 14; // log2(FrameSize*128)

	typedef struct packed {
		logic clear_acc;  // start a new bin
		logic mac_en;     // accumulate one product pair
		logic root_start; // launch square root on current sums
		logic root_step;  // advance one squaring phase or one bit of the root
	} dms_cmd_t;

	typedef struct packed {
		logic root_done;
	} dms_sts_t;

	// Q15 twiddles: cos(2*pi*i/128) and sin, half away from zero, saturated
	function automatic logic signed [15:0] cos_tw(input logic [IdxW-1:0] i);
		logic [4:0] r;
		logic [1:0] q;
		logic signed [15:0] c;
		logic signed [15:0] s;
		r = i[4:0];
		q = i[6:5];
		c = quarter(r);
		s = quarter(5'(32 - int'(r)) );
		if (r == 5'd0) s = 16'sd0;
		case (q)
			2'd0: cos_tw = c;
			2'd1: cos_tw = -s;
			2'd2: cos_tw = -c;
			default: cos_tw = s;
		endcase
	endfunction

	function automatic logic signed [15:0] sin_tw(input logic [IdxW-1:0] i);
		sin_tw = cos_tw(7'(int'(i) + 96));
	endfunction

	// cos(pi/2 * r/32) in Q15, r in 0..31
	function automatic logic signed [15:0] quarter(input logic [4:0] r);
		case (r)
			5'd0: quarter = 16'sd32767; 5'd1: quarter = 16'sd32729;
			5'd2: quarter = 16'sd32610; 5'd3: quarter = 16'sd32413;
			5'd4: quarter = 16'sd32138; 5'd5: quarter = 16'sd31786;
			5'd6: quarter = 16'sd31357; 5'd7: quarter = 16'sd30853;
			5'd8: quarter = 16'sd30274; 5'd9: quarter = 16'sd29622;
			5'd10: quarter = 16'sd28899; 5'd11: quarter = 16'sd28106;
			5'd12: quarter = 16'sd27246; 5'd13: quarter = 16'sd26320;
			5'd14: quarter = 16'sd25330; 5'd15: quarter = 16'sd24279;
			5'd16: quarter = 16'sd23170; 5'd17: quarter = 16'sd22006;
			5'd18: quarter = 16'sd20788; 5'd19: quarter = 16'sd19520;
			5'd20: quarter = 16'sd18205; 5'd21: quarter = 16'sd16846;
			5'd22: quarter = 16'sd15447; 5'd23: quarter = 16'sd14010;
			5'd24: quarter = 16'sd12540; 5'd25: quarter = 16'sd11039;
			5'd26: quarter = 16'sd9512; 5'd27: quarter = 16'sd7962;
			5'd28: quarter = 16'sd6393; 5'd29: quarter = 16'sd4808;
			5'd30: quarter = 16'sd3212; 5'd31: quarter = 16'sd1608;
			default: quarter = 16'sd0;
		endcase
	endfunction
endpackage

/* rtl/dms_datapath.sv */
// Datapath: frame memory, shared MAC pair, multi-cycle squaring and bit-serial square root.
`timescale 1ns / 1ps
module dms_datapath (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        wr_en,
	input  logic [dms_pkg::IdxW-1:0]    wr_addr,
	input  logic [dms_pkg::SampleW-1:0] wr_data,
	input  logic [dms_pkg::IdxW-1:0]    rd_addr,
	input  logic [dms_pkg::IdxW-1:0]    tw_idx,
	input  dms_pkg::dms_cmd_t           cmd,
	output dms_pkg::dms_sts_t           sts,
	output logic [dms_pkg::MagW-1:0]    mag
);
	logic [dms_pkg::SampleW-1:0] mem [dms_pkg::FrameSize];
	logic signed [dms_pkg::SampleW-1:0] x_s1;
	logic signed [15:0] c_s1, s_s1;
	logic signed [31:0] pc_s2, ps_s2;
	logic signed [dms_pkg::AccW-1:0] re_q, im_q;
	logic [dms_pkg::AccW-1:0] ar_q, ai_q;
	logic [dms_pkg::PowW-1:0] pow_q;
	logic [dms_pkg::RootW-1:0] root_q;
	logic [5:0] bit_q;
	logic [1:0] ph_q;
	logic mac_s1, mac_s2, busy_q, sq_q;
	logic [dms_pkg::AccW-1:0] are, aim;
	logic [19:0] ma_x, ma_y, mb_x, mb_y;
	logic [39:0] pa, pb;
	logic [dms_pkg::PowW-1:0] term, trial, cur;

	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= wr_data;
		x_s1 <= mem[rd_addr];
		c_s1 <= dms_pkg::cos_tw(tw_idx);
		s_s1 <= dms_pkg::sin_tw(tw_idx);
		pc_s2 <= x_s1 * c_s1;
		ps_s2 <= x_s1 * s_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mac_s1 <= 1'b0;
			mac_s2 <= 1'b0;
			busy_q <= 1'b0;
			sq_q <= 1'b0;
			ph_q <= '0;
			bit_q <= '0;
		end else begin
			mac_s1 <= cmd.mac_en;
			mac_s2 <= mac_s1;
			if (cmd.root_start) begin
				busy_q <= 1'b1;
				sq_q <= 1'b1;
				ph_q <= '0;
				bit_q <= 6'd39;
			end else if (cmd.root_step && busy_q) begin
				if (sq_q) begin
					if (ph_q == 2'd2) sq_q <= 1'b0;
					else ph_q <= ph_q + 2'd1;
				end else if (bit_q == 6'd0) busy_q <= 1'b0;
				else bit_q <= bit_q - 6'd1;
			end
		end
	end

	assign are = re_q[dms_pkg::AccW-1] ? -re_q : re_q;
	assign aim = im_q[dms_pkg::AccW-1] ? -im_q : im_q;

	// split each magnitude into 20-bit halves: low*low, then cross terms, then high*high
	always_comb begin
		case (ph_q)
			2'd0: begin
				ma_x = ar_q[19:0];
				ma_y = ar_q[19:0];
				mb_x = ai_q[19:0];
				mb_y = ai_q[19:0];
			end
			2'd1: begin
				ma_x = ar_q[39:20];
				ma_y = ar_q[19:0];
				mb_x = ai_q[39:20];
				mb_y = ai_q[19:0];
			end
			default: begin
				ma_x = ar_q[39:20];
				ma_y = ar_q[39:20];
				mb_x = ai_q[39:20];
				mb_y = ai_q[39:20];
			end
		endcase
		pa = ma_x * ma_y;
		pb = mb_x * mb_y;
		case (ph_q)
			2'd0: term = dms_pkg::PowW'(pa) + dms_pkg::PowW'(pb);
			2'd1: term = (dms_pkg::PowW'(pa) + dms_pkg::PowW'(pb)) << 21;
			default: term = (dms_pkg::PowW'(pa) + dms_pkg::PowW'(pb)) << 40;
		endcase
	end

	// restoring root: trial = (2*root + 2^b) * 2^b
	always_comb begin
		cur = dms_pkg::PowW'(root_q) << (bit_q + 6'd1);
		trial = cur + (dms_pkg::PowW'(1) << (7'(bit_q) << 1));
	end

	always_ff @(posedge clk) begin
		if (cmd.clear_acc) begin
			re_q <= '0;
			im_q <= '0;
		end else if (mac_s2) begin
			re_q <= re_q + dms_pkg::AccW'(pc_s2);
			im_q <= im_q - dms_pkg::AccW'(ps_s2);
		end
		if (cmd.root_start) begin
			ar_q <= are;
			ai_q <= aim;
			pow_q <= '0;
			root_q <= '0;
		end else if (cmd.root_step && busy_q) begin
			if (sq_q) pow_q <= pow_q + term;
			else if (trial <= pow_q) begin
				pow_q <= pow_q - trial;
				root_q <= root_q | (dms_pkg::RootW'(1) << bit_q);
			end
		end
	end

	assign sts.root_done = ~busy_q;
	logic [dms_pkg::RootW-1:0] q;
	assign q = root_q >> dms_pkg::DivShift;
	assign mag = (|q[dms_pkg::RootW-1:dms_pkg::MagW]) ? '1 : q[dms_pkg::MagW-1:0];
endmodule

/* rtl/dms_ctrl.sv */
// Controller: frame fill, bin/sample sequencing, output register load.
`timescale 1ns / 1ps
module dms_ctrl (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_fire,
	output logic                        in_rdy,
	output logic [dms_pkg::IdxW-1:0]    wr_addr,
	output logic [dms_pkg::IdxW-1:0]    rd_addr,
	output logic [dms_pkg::IdxW-1:0]    tw_idx,
	output dms_pkg::dms_cmd_t           cmd,
	input  dms_pkg::dms_sts_t           sts,
	output logic                        out_load,
	output logic [dms_pkg::BinW-1:0]    bin_q,
	input  logic                        out_busy
);
	localparam logic [2:0] S_FILL = 3'd0, S_MAC = 3'd1, S_DRAIN = 3'd2,
		S_ROOT = 3'd3, S_OUT = 3'd4;
	logic [2:0] state_q;
	logic [dms_pkg::IdxW-1:0] fill_q, n_q, tw_q;
	logic [1:0] drain_q;

	assign in_rdy = (state_q == S_FILL);
	assign wr_addr = fill_q;
	assign rd_addr = n_q;
	assign tw_idx = tw_q;

	always_comb begin
		cmd = '0;
		cmd.mac_en = (state_q == S_MAC);
		cmd.clear_acc = (state_q == S_FILL && in_fire && fill_q == 7'd127)
			|| (state_q == S_OUT);
		cmd.root_start = (state_q == S_DRAIN && drain_q == 2'd2);
		cmd.root_step = (state_q == S_ROOT);
	end
	// hold the finished bin until the output register is free
	assign out_load = (state_q == S_ROOT && sts.root_done && !out_busy);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_FILL;
			fill_q <= '0;
			n_q <= '0;
			tw_q <= '0;
			bin_q <= '0;
			drain_q <= '0;
		end else begin
			case (state_q)
				S_FILL: if (in_fire) begin
					fill_q <= fill_q + 7'd1;
					if (fill_q == 7'd127) begin
						state_q <= S_MAC;
						bin_q <= '0;
						n_q <= '0;
						tw_q <= '0;
					end
				end
				S_MAC: begin
					n_q <= n_q + 7'd1;
					tw_q <= tw_q + 7'(bin_q);
					if (n_q == 7'd127) begin
						state_q <= S_DRAIN;
						drain_q <= '0;
					end
				end
				S_DRAIN: begin
					drain_q <= drain_q + 2'd1;
					if (drain_q == 2'd2) state_q <= S_ROOT;
				end
				S_ROOT: if (sts.root_done && !out_busy) state_q <= S_OUT;
				S_OUT: begin
					if (bin_q == 6'd63) state_q <= S_FILL;
					else begin
						bin_q <= bin_q + 6'd1;
						n_q <= '0;
						tw_q <= '0;
						state_q <= S_MAC;
					end
				end
				default: state_q <= S_FILL;
			endcase
		end
	end
endmodule

/* rtl/dft_magnitude_spectrum.sv */
// Top level: frame DFT magnitude spectrum with stream ports.
// Usage: feed signed 16-bit samples on the s_axis channel. After every 128th
// transfer the block computes bins 0..63 with one shared MAC pair, a pipeline
// drain, squaring of the low, cross and high terms with 20-bit multipliers and
// a bit-serial square root of 40 steps, bin after bin. No sample is taken
// during the computation. Each bin leaves through an output register on
// m_axis; the last bin of a frame carries tlast. A stalled receiver holds the
// result; the next bin is computed and then waits until the register is free.
// Once the last bin sits in the register the input opens again, even while
// that bin is stalled. Reset clears the fill count and the sequencer; the
// frame memory holds whatever was there and is fully rewritten before each
// computation.
`timescale 1ns / 1ps
module dft_magnitude_spectrum (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,  // [15:0] sample
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,  // [5:0] bin_index, [29:6] magnitude, zero pad
	output logic        m_axis_tlast
);
	logic in_fire, out_load;
	logic [dms_pkg::IdxW-1:0] wr_addr, rd_addr, tw_idx;
	dms_pkg::dms_cmd_t cmd;
	dms_pkg::dms_sts_t sts;
	logic [dms_pkg::MagW-1:0] mag;
	logic [dms_pkg::BinW-1:0] bin;
	logic out_busy;

	assign in_fire = s_axis_tvalid && s_axis_tready;

	dms_ctrl u_ctrl (.clk, .arst_n, .in_fire, .in_rdy(s_axis_tready), .wr_addr,
		.rd_addr, .tw_idx, .cmd, .sts, .out_load, .bin_q(bin), .out_busy);

	dms_datapath u_dp (.clk, .arst_n, .wr_en(in_fire), .wr_addr,
		.wr_data(s_axis_tdata), .rd_addr, .tw_idx, .cmd, .sts, .mag);

	assign out_busy = m_axis_tvalid && !m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) m_axis_tvalid <= 1'b0;
		else if (out_load) m_axis_tvalid <= 1'b1;
		else if (m_axis_tready) m_axis_tvalid <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_axis_tdata <= {2'b00, mag, bin};
			m_axis_tlast <= (bin == 6'd63);
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
		&& $stable(m_axis_tlast)) else $error("result changed while stalled");
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> !out_busy) else $error("result overwritten");
	a_root_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.root_start |=> !cmd.root_start) else $error("root restarted");
endmodule

/* test/tb_dft_magnitude_spectrum.sv */
// Testbench for the frame DFT magnitude block: self-checking stream test with its own spectrum predictor.
`timescale 1ns / 1ps
module tb_dft_magnitude_spectrum;
	localparam int Bins = dms_pkg::FrameSize / 2;
	localparam int StallLimit = 40000;
	localparam int HoldCycles = 3000;

	typedef struct {
		logic [dms_pkg::BinW-1:0] bin;
		logic [dms_pkg::MagW-1:0] mag;
		logic                     last;
	} bin_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [15:0] s_axis_tdata = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [31:0] m_axis_tdata;
	logic        m_axis_tlast;

	logic signed [15:0] cos_q15 [dms_pkg::FrameSize];
	logic signed [15:0] sin_q15 [dms_pkg::FrameSize];
	logic signed [15:0] frame_buf [dms_pkg::FrameSize];
	int unsigned fill_cnt = 0;
	bin_result_t spectrum_q[$];

	int unsigned send_idle_pct = 0;
	int unsigned recv_idle_pct = 0;
	bit hold_req = 1'b0;
	int unsigned hold_cnt = 0;
	int unsigned err_cnt = 0;
	int unsigned samples_sent = 0;
	int unsigned bins_seen = 0;
	int unsigned frames_done = 0;
	int unsigned idle_cyc = 0;

	dft_magnitude_spectrum u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tlast(m_axis_tlast)
	);

	always #2 clk = ~clk;

	function automatic logic signed [15:0] q30_to_q15(input longint v);
		longint unsigned m;
		if (v < 0) v = 0;
		m = (longint'(v) + 64'd16384) >> 15;
		if (m > 64'd32767) m = 64'd32767;
		return 16'(m);
	endfunction

	// integer Taylor series in Q30 for the first quadrant, then fold by quadrant
	function automatic void build_twiddles();
		longint unsigned x, x2, tc, ts, q4, quad, rem;
		longint cs, ss;
		logic signed [15:0] c, s;
		for (int i = 0; i < dms_pkg::FrameSize; i++) begin
			q4 = 4 * i;
			quad = (q4 / dms_pkg::FrameSize) & 3;
			rem = q4 % dms_pkg::FrameSize;
			x = (64'd1686629713 * rem) / dms_pkg::FrameSize;
			x2 = (x * x) >> 30;
			tc = 64'd1 << 30;
			ts = x;
			cs = longint'(tc);
			ss = longint'(ts);
			for (int k = 1; k <= 14; k++) begin
				tc = ((tc * x2) >> 30) / ((2 * k - 1) * (2 * k));
				ts = ((ts * x2) >> 30) / ((2 * k) * (2 * k + 1));
				if (k % 2 == 1) begin
					cs -= longint'(tc);
					ss -= longint'(ts);
				end else begin
					cs += longint'(tc);
					ss += longint'(ts);
				end
			end
			c = q30_to_q15(cs);
			s = q30_to_q15(ss);
			case (quad)
				0: begin cos_q15[i] = c;  sin_q15[i] = s;  end
				1: begin cos_q15[i] = -s; sin_q15[i] = c;  end
				2: begin cos_q15[i] = -c; sin_q15[i] = -s; end
				default: begin cos_q15[i] = s; sin_q15[i] = -c; end
			endcase
		end
	endfunction

	function automatic void predict_spectrum();
		longint re, im;
		longint unsigned a, b, r, cand, mag;
		logic [127:0] pw;
		bin_result_t res;
		for (int k = 0; k < Bins; k++) begin
			re = 0;
			im = 0;
			for (int n = 0; n < dms_pkg::FrameSize; n++) begin
				re += longint'(frame_buf[n])
					* longint'(cos_q15[(k * n) % dms_pkg::FrameSize]);
				im -= longint'(frame_buf[n])
					* longint'(sin_q15[(k * n) % dms_pkg::FrameSize]);
			end
			a = (re < 0) ? -re : re;
			b = (im < 0) ? -im : im;
			pw = 128'(a) * 128'(a) + 128'(b) * 128'(b);
			r = 0;
			for (int bt = 40; bt >= 0; bt--) begin
				cand = r | (64'd1 << bt);
				if (128'(cand) * 128'(cand) <= pw) r = cand;
			end
			mag = r >> dms_pkg::DivShift;
			if (mag > 64'hFFFFFF) mag = 64'hFFFFFF;
			res.bin = dms_pkg::BinW'(k);
			res.mag = dms_pkg::MagW'(mag);
			res.last = (k == Bins - 1);
			spectrum_q.push_back(res);
		end
	endfunction

	// offer one sample, hold it until the transfer, then maybe idle
	task automatic send_sample(input logic signed [15:0] smp);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= smp;
		do @(negedge clk); while (!s_axis_tready);
		@(posedge clk);
		samples_sent++;
		frame_buf[fill_cnt] = smp;
		fill_cnt++;
		if (fill_cnt == dms_pkg::FrameSize) begin
			fill_cnt = 0;
			frames_done++;
			predict_spectrum();
		end
		if ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= 16'($urandom);
			repeat ($urandom_range(6, 1)) @(posedge clk);
		end
	endtask

	function automatic logic signed [15:0] rand_sample();
		case ($urandom_range(3))
			0: return 16'($urandom);
			1: return 16'($signed(8'($urandom)));
			2: return $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
			default: return 16'($signed(12'($urandom)));
		endcase
	endfunction

	task automatic test_extremes();
		// impulse, both extremes, then alternating full scale
		for (int n = 0; n < dms_pkg::FrameSize; n++) begin
			if (n == 0) send_sample(16'sh7FFF);
			else if (n == 1) send_sample(16'sh8000);
			else if (n < 8) send_sample(16'sh0000);
			else send_sample((n % 2) ? 16'sh8000 : 16'sh7FFF);
		end
	endtask

	// hold the receiver off across the end of a full-scale DC frame while samples keep coming
	task automatic test_output_stall();
		for (int n = 0; n < dms_pkg::FrameSize; n++) begin
			if (n == dms_pkg::FrameSize - 1) hold_req = 1'b1;
			send_sample(16'sh8000);
		end
		for (int n = 0; n < 16; n++) send_sample(rand_sample());
	endtask

	// finish the frame that is under way with random samples
	task automatic test_random_frame();
		do send_sample(rand_sample()); while (fill_cnt != 0);
	endtask

	always @(posedge clk) begin
		if (hold_req) begin
			hold_req = 1'b0;
			hold_cnt = HoldCycles;
		end
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else if (hold_cnt > 0) begin
			hold_cnt--;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// sample at the falling edge: a transfer takes place at the next rising edge
	always @(negedge clk) begin
		bin_result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			bins_seen++;
			if (spectrum_q.size() == 0) begin
				err_cnt++;
				$error("unexpected bin: bin_index %0d", m_axis_tdata[5:0]);
			end else begin
				want = spectrum_q.pop_front();
				if (m_axis_tdata[5:0] !== want.bin) begin
					err_cnt++;
					$error("bin_index: expected %0d, got %0d", want.bin, m_axis_tdata[5:0]);
				end
				if (m_axis_tdata[29:6] !== want.mag) begin
					err_cnt++;
					$error("magnitude: expected %0d, got %0d", want.mag, m_axis_tdata[29:6]);
				end
				if (m_axis_tlast !== want.last) begin
					err_cnt++;
					$error("last_bin: expected %0d, got %0d", want.last, m_axis_tlast);
				end
				if (m_axis_tdata[31:30] !== 2'b00) begin
					err_cnt++;
					$error("pad: expected 0, got %0d", m_axis_tdata[31:30]);
				end
			end
		end
		if (arst_n && ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)))
			idle_cyc = 0;
		else
			idle_cyc++;
		if (idle_cyc >= StallLimit) begin
			$display("watchdog: no transfer for %0d cycles", StallLimit);
			$display("tb_dft_magnitude_spectrum: done, errors");
			$finish;
		end
	end

	initial begin
		build_twiddles();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle_pct = 24;
		recv_idle_pct = 74;
		test_extremes();

		send_idle_pct = 74;
		recv_idle_pct = 24;
		test_output_stall();

		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random_frame();

		s_axis_tvalid <= 1'b0;
		wait (spectrum_q.size() == 0);
		repeat (300) @(posedge clk);
		$display("covered %0d samples, %0d complete frames, %0d bins checked",
			samples_sent, frames_done, bins_seen);
		$display("with impulse, alternating, full-scale DC and random frames, both idle patterns");
		$display("and a long output stall that backs up the input");
		if (err_cnt == 0 && spectrum_q.size() == 0)
			$display("tb_dft_magnitude_spectrum: done, clean");
		else
			$display("tb_dft_magnitude_spectrum: done, errors");
		$finish;
	end
endmodule
